// ===== rtl/tcs_pkg.sv =====
// Shared constants, types and codes for the text console engine.
package tcs_pkg;

   localparam int COLUMNS       = 80;
   localparam int ROWS          = 25;
   localparam int HISTORY_LINES = 200;

   localparam int CELLS      = COLUMNS * ROWS;
   localparam int RING_DEPTH = HISTORY_LINES * COLUMNS;

   localparam int POS_W   = 11;
   localparam int IDX_W   = $clog2(CELLS);
   localparam int ROW_W   = $clog2(ROWS);
   localparam int COL_W   = $clog2(COLUMNS);
   localparam int HEAD_W  = $clog2(HISTORY_LINES);
   localparam int CNT_W   = $clog2(HISTORY_LINES + 1);
   localparam int SLOT_W  = $clog2(2 * HISTORY_LINES);
   localparam int RING_AW = $clog2(RING_DEPTH);
   localparam int CELL_W  = 16;

   localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0700;
   localparam logic [CELL_W-1:0] SPACE_CELL = 16'h0720;

   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SPACE = 8'h20;

   // reciprocal of the row length, underestimates by less than one
   localparam int DIV_SHIFT   = 17;
   localparam int DIV_RECIP   = (1 << DIV_SHIFT) / COLUMNS;
   localparam int DIV_RECIP_W = $clog2(DIV_RECIP + 1);

   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 32;
   localparam logic [1:0] CSR_TEXT_COLOR   = 2'd0;
   localparam logic [1:0] CSR_PRINT_ENABLE = 2'd1;
   localparam logic [1:0] CSR_MASK_INPUT   = 2'd2;

   typedef enum logic [3:0] {
      CMD_PUT       = 4'd0,
      CMD_PUT_ATTR  = 4'd1,
      CMD_RIGHT     = 4'd2,
      CMD_LEFT      = 4'd3,
      CMD_UP        = 4'd4,
      CMD_DOWN      = 4'd5,
      CMD_BACKSPACE = 4'd6,
      CMD_BLANK     = 4'd7,
      CMD_SKIP      = 4'd8,
      CMD_MARK      = 4'd9,
      CMD_SET       = 4'd10,
      CMD_CLEAR     = 4'd11,
      CMD_VIEW_UP   = 4'd12,
      CMD_VIEW_DOWN = 4'd13,
      CMD_READ      = 4'd14
   } cmd_type;

   typedef enum logic [4:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_DIV,
      ST_NL,
      ST_CHK_END,
      ST_SC_RING_RD,
      ST_SC_RING_WR,
      ST_SC_MOVE_RD,
      ST_SC_MOVE_WR,
      ST_SC_BLANK,
      ST_SC_DONE,
      ST_SKIP_RD,
      ST_SKIP_CHK,
      ST_CLEAR,
      ST_COPY_RD,
      ST_COPY_WR,
      ST_VIEW_UP,
      ST_RD_ADDR,
      ST_RD_WAIT,
      ST_RESP
   } state_type;

   typedef enum logic [1:0] {
      SRC_SCREEN,
      SRC_RING,
      SRC_SNAP
   } src_type;

   typedef struct packed {
      logic [3:0]       command;
      logic [7:0]       char_code;
      logic [7:0]       attr;
      logic [POS_W-1:0] amount;
      logic [POS_W-1:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0] cursor_pos;
      logic [POS_W-1:0] line_start_pos;
      logic [7:0]       view_offset;
      logic [7:0]       cell_char;
      logic [7:0]       cell_attr;
      logic             scrolled;
   } rsp_type;

   typedef struct packed {
      logic [ROW_W-1:0] q;
      logic [COL_W-1:0] r;
   } div_res_type;

endpackage

// ===== rtl/tcs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tcs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/tcs_div.sv =====
// Two-stage divide by the row length: reciprocal multiply, then one correction.
module tcs_div (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [tcs_pkg::IDX_W-1:0] x,
   output logic                    done,
   output tcs_pkg::div_res_type    res
);

   localparam int PW = tcs_pkg::IDX_W + tcs_pkg::DIV_RECIP_W;

   logic [PW-1:0]                 prod;
   logic [tcs_pkg::ROW_W-1:0]     q0_ff, q0_in;
   logic [tcs_pkg::IDX_W-1:0]     x_ff;
   logic                          s1_ff, done_ff;
   logic [tcs_pkg::IDX_W-1:0]     r0;
   tcs_pkg::div_res_type          res_ff, res_in;

   always_comb begin
      prod  = PW'(x) * PW'(tcs_pkg::DIV_RECIP);
      q0_in = tcs_pkg::ROW_W'(prod >> tcs_pkg::DIV_SHIFT);
      r0    = x_ff - tcs_pkg::IDX_W'(q0_ff) * tcs_pkg::IDX_W'(tcs_pkg::COLUMNS);
      if (r0 >= tcs_pkg::IDX_W'(tcs_pkg::COLUMNS)) begin
         res_in.q = q0_ff + 1'b1;
         res_in.r = tcs_pkg::COL_W'(r0 - tcs_pkg::IDX_W'(tcs_pkg::COLUMNS));
      end else begin
         res_in.q = q0_ff;
         res_in.r = tcs_pkg::COL_W'(r0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         s1_ff   <= start;
         done_ff <= s1_ff;
      end
      if (start) begin
         q0_ff <= q0_in;
         x_ff  <= x;
      end
      if (s1_ff) begin
         res_ff <= res_in;
      end
   end

   assign done = done_ff;
   assign res  = res_ff;

endmodule

// ===== rtl/text_console_with_scrollback_top.sv =====
// Text console engine: command sequencer, screen, scrollback ring and snapshot.
// The strobe is registered from the response step. Cursor moves, mark, set, blank,
// backspace and view down go straight from the execute step to it; put and right check the
// screen end and may scroll (top row to the ring, rows moved up, last row blanked); skip
// reads back cell by cell; clear sweeps the screen; view up from live copies the snapshot.
// One item at a time. Reset sweeps the screen to blank with busy high; results never stall.
module text_console_with_scrollback_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  tcs_pkg::req_type             req_payload,
   output logic                         rsp_strobe,
   output tcs_pkg::rsp_type             rsp_payload,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [tcs_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [tcs_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [tcs_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                         csr_pready
);

   localparam int IW = tcs_pkg::IDX_W;
   localparam int CW = tcs_pkg::CNT_W;
   localparam int RW = tcs_pkg::RING_AW;
   localparam int SW = tcs_pkg::SLOT_W;
   localparam logic [IW-1:0] CELLS_I  = IW'(tcs_pkg::CELLS);
   localparam logic [IW-1:0] COLS_I   = IW'(tcs_pkg::COLUMNS);
   localparam logic [IW-1:0] LAST_I   = IW'(tcs_pkg::CELLS - 1);
   localparam logic [IW-1:0] MOVE_END = IW'(tcs_pkg::CELLS - tcs_pkg::COLUMNS - 1);
   localparam logic [IW-1:0] BLANK_ST = IW'(tcs_pkg::CELLS - tcs_pkg::COLUMNS);

   tcs_pkg::state_type state_ff, state_in;
   tcs_pkg::cmd_type   cmd_ff, cmd_in;
   tcs_pkg::src_type   src_ff, src_in;
   logic [7:0]    ch_ff, ch_in, attr_ff, attr_in;
   logic [IW-1:0] amount_ff, amount_in, cidx_ff, cidx_in;
   logic [IW-1:0] cursor_ff, cursor_in, ls_ff, ls_in, idx_ff, idx_in;
   logic [tcs_pkg::HEAD_W-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in, view_ff, view_in;
   logic [tcs_pkg::CELL_W-1:0] cell_ff, cell_in;
   logic          scrolled_ff, scrolled_in;
   logic          rsp_strobe_ff, rsp_strobe_in;
   tcs_pkg::rsp_type rsp_ff, rsp_in;
   logic [7:0]    text_color_ff;
   logic          print_en_ff, mask_ff;

   logic          scr_we, ring_we, snap_we;
   logic [IW-1:0] scr_waddr, scr_raddr, snap_waddr, snap_raddr;
   logic [RW-1:0] ring_waddr, ring_raddr;
   logic [tcs_pkg::CELL_W-1:0] scr_wdata, scr_rdata, ring_rdata, snap_rdata;

   logic          div_start, div_done;
   logic [IW-1:0] div_x;
   tcs_pkg::div_res_type div_res;

   logic          accept, csr_wr;
   logic [CW-1:0] shown, back, backm;
   logic [SW-1:0] slot_sum;
   logic [tcs_pkg::HEAD_W-1:0] slot;
   logic [CW+IW-1:0] view_sum;

   assign accept = start && !busy;
   assign busy   = state_ff != tcs_pkg::ST_IDLE;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      csr_prdata = '0;
      unique case (csr_paddr[3:2])
         tcs_pkg::CSR_TEXT_COLOR:   csr_prdata = tcs_pkg::CSR_DW'(text_color_ff);
         tcs_pkg::CSR_PRINT_ENABLE: csr_prdata = tcs_pkg::CSR_DW'(print_en_ff);
         tcs_pkg::CSR_MASK_INPUT:   csr_prdata = tcs_pkg::CSR_DW'(mask_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_color_ff <= 8'h07;
         print_en_ff   <= 1'b1;
         mask_ff       <= 1'b0;
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            tcs_pkg::CSR_TEXT_COLOR:   text_color_ff <= csr_pwdata[7:0];
            tcs_pkg::CSR_PRINT_ENABLE: print_en_ff   <= csr_pwdata[0];
            tcs_pkg::CSR_MASK_INPUT:   mask_ff       <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   tcs_ram #(.WIDTH(tcs_pkg::CELL_W), .DEPTH(tcs_pkg::CELLS)) u_screen (
      .clock(clock), .we(scr_we), .waddr(scr_waddr), .wdata(scr_wdata),
      .raddr(scr_raddr), .rdata(scr_rdata)
   );

   tcs_ram #(.WIDTH(tcs_pkg::CELL_W), .DEPTH(tcs_pkg::RING_DEPTH)) u_ring (
      .clock(clock), .we(ring_we), .waddr(ring_waddr), .wdata(scr_rdata),
      .raddr(ring_raddr), .rdata(ring_rdata)
   );

   tcs_ram #(.WIDTH(tcs_pkg::CELL_W), .DEPTH(tcs_pkg::CELLS)) u_snap (
      .clock(clock), .we(snap_we), .waddr(snap_waddr), .wdata(scr_rdata),
      .raddr(snap_raddr), .rdata(snap_rdata)
   );

   assign div_x = (cmd_ff == tcs_pkg::CMD_READ) ? cidx_ff : cursor_ff;

   tcs_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .x(div_x),
      .done(div_done), .res(div_res)
   );

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      src_in        = src_ff;
      ch_in         = ch_ff;
      attr_in       = attr_ff;
      amount_in     = amount_ff;
      cidx_in       = cidx_ff;
      cursor_in     = cursor_ff;
      ls_in         = ls_ff;
      idx_in        = idx_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      view_in       = view_ff;
      cell_in       = cell_ff;
      scrolled_in   = scrolled_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      scr_we        = 1'b0;
      scr_waddr     = cursor_ff;
      scr_wdata     = tcs_pkg::BLANK_CELL;
      scr_raddr     = idx_ff;
      ring_we       = 1'b0;
      ring_waddr    = RW'(head_ff) * RW'(tcs_pkg::COLUMNS) + RW'(idx_ff);
      ring_raddr    = '0;
      snap_we       = 1'b0;
      snap_waddr    = idx_ff;
      snap_raddr    = '0;
      div_start     = 1'b0;

      shown    = (view_ff < CW'(tcs_pkg::ROWS)) ? view_ff : CW'(tcs_pkg::ROWS);
      back     = view_ff - CW'(div_res.q);
      backm    = (back == CW'(tcs_pkg::HISTORY_LINES)) ? '0 : back;
      slot_sum = SW'(head_ff) + SW'(tcs_pkg::HISTORY_LINES) - SW'(backm);
      slot     = (slot_sum >= SW'(tcs_pkg::HISTORY_LINES)) ?
                 tcs_pkg::HEAD_W'(slot_sum - SW'(tcs_pkg::HISTORY_LINES)) :
                 tcs_pkg::HEAD_W'(slot_sum);
      view_sum = (CW+IW)'(view_ff) + (CW+IW)'(amount_ff);

      unique case (state_ff)
         tcs_pkg::ST_INIT, tcs_pkg::ST_CLEAR: begin
            scr_we    = 1'b1;
            scr_waddr = idx_ff;
            idx_in    = idx_ff + 1'b1;
            if (idx_ff == LAST_I) begin
               state_in = (state_ff == tcs_pkg::ST_INIT) ? tcs_pkg::ST_IDLE
                                                         : tcs_pkg::ST_RESP;
            end
         end
         tcs_pkg::ST_IDLE: begin
            if (accept) begin
               cmd_in      = tcs_pkg::cmd_type'(req_payload.command);
               ch_in       = (mask_ff && req_payload.char_code != tcs_pkg::CH_LF) ?
                             tcs_pkg::CH_STAR : req_payload.char_code;
               attr_in     = (req_payload.command == tcs_pkg::CMD_PUT) ?
                             text_color_ff : req_payload.attr;
               amount_in   = req_payload.amount;
               cidx_in     = req_payload.cell_index;
               cell_in     = '0;
               scrolled_in = 1'b0;
               state_in    = tcs_pkg::ST_EXEC;
            end
         end
         tcs_pkg::ST_EXEC: begin
            state_in = tcs_pkg::ST_RESP;
            unique case (cmd_ff)
               tcs_pkg::CMD_PUT, tcs_pkg::CMD_PUT_ATTR: begin
                  if (print_en_ff) begin
                     view_in = '0;
                     if (ch_ff == tcs_pkg::CH_LF || ch_ff == tcs_pkg::CH_CR) begin
                        div_start = 1'b1;
                        state_in  = tcs_pkg::ST_DIV;
                     end else if (ch_ff == tcs_pkg::CH_BS) begin
                        if (cursor_ff > ls_ff) begin
                           cursor_in = cursor_ff - 1'b1;
                           scr_we    = 1'b1;
                           scr_waddr = cursor_ff - 1'b1;
                        end
                     end else begin
                        scr_we    = 1'b1;
                        scr_wdata = {attr_ff, ch_ff};
                        cursor_in = cursor_ff + 1'b1;
                        state_in  = tcs_pkg::ST_CHK_END;
                     end
                  end
               end
               tcs_pkg::CMD_RIGHT: begin
                  cursor_in = cursor_ff + 1'b1;
                  state_in  = tcs_pkg::ST_CHK_END;
               end
               tcs_pkg::CMD_LEFT: begin
                  if (cursor_ff != '0) cursor_in = cursor_ff - 1'b1;
               end
               tcs_pkg::CMD_UP: begin
                  if (cursor_ff >= COLS_I) cursor_in = cursor_ff - COLS_I;
               end
               tcs_pkg::CMD_DOWN: begin
                  if (cursor_ff < BLANK_ST) cursor_in = cursor_ff + COLS_I;
               end
               tcs_pkg::CMD_BACKSPACE: begin
                  if (cursor_ff > ls_ff) begin
                     cursor_in = cursor_ff - 1'b1;
                     scr_we    = 1'b1;
                     scr_waddr = cursor_ff - 1'b1;
                  end
               end
               tcs_pkg::CMD_BLANK: begin
                  scr_we    = 1'b1;
                  scr_wdata = tcs_pkg::SPACE_CELL;
               end
               tcs_pkg::CMD_SKIP: begin
                  if (cursor_ff > ls_ff) begin
                     idx_in   = cursor_ff - 1'b1;
                     state_in = tcs_pkg::ST_SKIP_RD;
                  end
               end
               tcs_pkg::CMD_MARK: ls_in = cursor_ff;
               tcs_pkg::CMD_SET: begin
                  cursor_in = (amount_ff >= CELLS_I) ? LAST_I : amount_ff;
               end
               tcs_pkg::CMD_CLEAR: begin
                  idx_in    = '0;
                  cursor_in = '0;
                  ls_in     = '0;
                  state_in  = tcs_pkg::ST_CLEAR;
               end
               tcs_pkg::CMD_VIEW_UP: begin
                  idx_in   = '0;
                  state_in = (view_ff == '0) ? tcs_pkg::ST_COPY_RD : tcs_pkg::ST_VIEW_UP;
               end
               tcs_pkg::CMD_VIEW_DOWN: begin
                  view_in = ((CW+IW)'(amount_ff) >= (CW+IW)'(view_ff)) ? '0 :
                            view_ff - CW'(amount_ff);
               end
               tcs_pkg::CMD_READ: begin
                  if (cidx_ff < CELLS_I) begin
                     if (view_ff == '0) begin
                        scr_raddr = cidx_ff;
                        src_in    = tcs_pkg::SRC_SCREEN;
                        state_in  = tcs_pkg::ST_RD_WAIT;
                     end else begin
                        div_start = 1'b1;
                        state_in  = tcs_pkg::ST_DIV;
                     end
                  end
               end
               default: ;
            endcase
         end
         tcs_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = (cmd_ff == tcs_pkg::CMD_READ) ? tcs_pkg::ST_RD_ADDR
                                                        : tcs_pkg::ST_NL;
            end
         end
         tcs_pkg::ST_NL: begin
            if (ch_ff == tcs_pkg::CH_LF) begin
               cursor_in = cursor_ff + (COLS_I - IW'(div_res.r));
            end else begin
               cursor_in = cursor_ff - IW'(div_res.r);
            end
            state_in = tcs_pkg::ST_CHK_END;
         end
         tcs_pkg::ST_CHK_END: begin
            if (cursor_ff >= CELLS_I) begin
               idx_in      = '0;
               scrolled_in = 1'b1;
               state_in    = tcs_pkg::ST_SC_RING_RD;
            end else begin
               state_in = tcs_pkg::ST_RESP;
            end
         end
         tcs_pkg::ST_SC_RING_RD: state_in = tcs_pkg::ST_SC_RING_WR;
         tcs_pkg::ST_SC_RING_WR: begin
            ring_we = 1'b1;
            if (idx_ff == COLS_I - 1'b1) begin
               idx_in   = '0;
               state_in = tcs_pkg::ST_SC_MOVE_RD;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = tcs_pkg::ST_SC_RING_RD;
            end
         end
         tcs_pkg::ST_SC_MOVE_RD: begin
            scr_raddr = idx_ff + COLS_I;
            state_in  = tcs_pkg::ST_SC_MOVE_WR;
         end
         tcs_pkg::ST_SC_MOVE_WR: begin
            scr_we    = 1'b1;
            scr_waddr = idx_ff;
            scr_wdata = scr_rdata;
            idx_in    = idx_ff + 1'b1;
            state_in  = (idx_ff == MOVE_END) ? tcs_pkg::ST_SC_BLANK
                                             : tcs_pkg::ST_SC_MOVE_RD;
         end
         tcs_pkg::ST_SC_BLANK: begin
            scr_we    = 1'b1;
            scr_waddr = idx_ff;
            idx_in    = idx_ff + 1'b1;
            if (idx_ff == LAST_I) state_in = tcs_pkg::ST_SC_DONE;
         end
         tcs_pkg::ST_SC_DONE: begin
            head_in = (head_ff == tcs_pkg::HEAD_W'(tcs_pkg::HISTORY_LINES - 1)) ?
                      '0 : head_ff + 1'b1;
            if (count_ff < CW'(tcs_pkg::HISTORY_LINES)) count_in = count_ff + 1'b1;
            cursor_in = cursor_ff - COLS_I;
            // only a put pulls the line start up with the text
            if (cmd_ff == tcs_pkg::CMD_PUT || cmd_ff == tcs_pkg::CMD_PUT_ATTR) begin
               ls_in = (ls_ff >= COLS_I) ? ls_ff - COLS_I : '0;
            end
            state_in = tcs_pkg::ST_RESP;
         end
         tcs_pkg::ST_SKIP_RD: state_in = tcs_pkg::ST_SKIP_CHK;
         tcs_pkg::ST_SKIP_CHK: begin
            if (scr_rdata[7:0] == tcs_pkg::CH_SPACE) begin
               scr_we    = 1'b1;
               scr_waddr = idx_ff;
               scr_wdata = tcs_pkg::SPACE_CELL;
               if (idx_ff == ls_ff) begin
                  cursor_in = ls_ff;
                  state_in  = tcs_pkg::ST_RESP;
               end else begin
                  idx_in   = idx_ff - 1'b1;
                  state_in = tcs_pkg::ST_SKIP_RD;
               end
            end else begin
               cursor_in = idx_ff + 1'b1;
               state_in  = tcs_pkg::ST_RESP;
            end
         end
         tcs_pkg::ST_COPY_RD: state_in = tcs_pkg::ST_COPY_WR;
         tcs_pkg::ST_COPY_WR: begin
            snap_we = 1'b1;
            idx_in  = idx_ff + 1'b1;
            state_in = (idx_ff == LAST_I) ? tcs_pkg::ST_VIEW_UP : tcs_pkg::ST_COPY_RD;
         end
         tcs_pkg::ST_VIEW_UP: begin
            view_in  = (view_sum > (CW+IW)'(count_ff)) ? count_ff : CW'(view_sum);
            state_in = tcs_pkg::ST_RESP;
         end
         tcs_pkg::ST_RD_ADDR: begin
            // ring rows on top, oldest first, then the snapshot's top rows
            if (CW'(div_res.q) < shown) begin
               ring_raddr = RW'(slot) * RW'(tcs_pkg::COLUMNS) + RW'(div_res.r);
               src_in     = tcs_pkg::SRC_RING;
            end else begin
               snap_raddr = cidx_ff - IW'(shown) * COLS_I;
               src_in     = tcs_pkg::SRC_SNAP;
            end
            state_in = tcs_pkg::ST_RD_WAIT;
         end
         tcs_pkg::ST_RD_WAIT: begin
            unique case (src_ff)
               tcs_pkg::SRC_RING: cell_in = ring_rdata;
               tcs_pkg::SRC_SNAP: cell_in = snap_rdata;
               default:           cell_in = scr_rdata;
            endcase
            state_in = tcs_pkg::ST_RESP;
         end
         tcs_pkg::ST_RESP: begin
            rsp_strobe_in         = 1'b1;
            rsp_in.cursor_pos     = tcs_pkg::POS_W'(cursor_ff);
            rsp_in.line_start_pos = tcs_pkg::POS_W'(ls_ff);
            rsp_in.view_offset    = 8'(view_ff);
            rsp_in.cell_char      = cell_ff[7:0];
            rsp_in.cell_attr      = cell_ff[15:8];
            rsp_in.scrolled       = scrolled_ff;
            state_in              = tcs_pkg::ST_IDLE;
         end
         default: state_in = tcs_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tcs_pkg::ST_INIT;
         idx_ff        <= '0;
         cursor_ff     <= '0;
         ls_ff         <= '0;
         head_ff       <= '0;
         count_ff      <= '0;
         view_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         cursor_ff     <= cursor_in;
         ls_ff         <= ls_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         view_ff       <= view_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      cmd_ff      <= cmd_in;
      src_ff      <= src_in;
      ch_ff       <= ch_in;
      attr_ff     <= attr_in;
      amount_ff   <= amount_in;
      cidx_ff     <= cidx_in;
      cell_ff     <= cell_in;
      scrolled_ff <= scrolled_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   a_strobe_after_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == tcs_pkg::ST_RESP))
      else $error("result beat without a response step");

   a_cursor_on_screen: assert property (@(posedge clock) disable iff (reset)
      state_ff == tcs_pkg::ST_IDLE |-> cursor_ff < CELLS_I && ls_ff < CELLS_I)
      else $error("cursor or line start off screen while idle");

   a_view_clamped: assert property (@(posedge clock) disable iff (reset)
      view_ff <= count_ff)
      else $error("view offset beyond scrollback fill");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy && !rsp_strobe)
      else $error("accepted beat did not make the block busy");

endmodule
